// ===== hw/rtl/cgpw_pkg.sv =====
// Shared constants, types and the saturation helper for the chaos-game point walker.
package cgpw_pkg;

  localparam int unsigned NumAnchorsDefault = 4;
  localparam int unsigned CoordWidthDefault = 16;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgDataBits = 32;

  localparam logic [CfgIdxBits-1:0] CfgDistFactor = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgStartPoint = 3'd5;

  localparam logic [15:0] DistFactorReset = 16'h8000;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [18:0] wide_coord_t;

  typedef struct packed {
    coord_t max_y;
    coord_t min_y;
    coord_t max_x;
    coord_t min_x;
    coord_t point_y;
    coord_t point_x;
  } result_t;

  function automatic coord_t sat_coord(wide_coord_t v, coord_t lo, coord_t hi);
    wide_coord_t lo_w;
    wide_coord_t hi_w;
    coord_t res;
    lo_w = wide_coord_t'(lo);
    hi_w = wide_coord_t'(hi);
    if (v > hi_w) begin
      res = hi;
    end else if (v < lo_w) begin
      res = lo;
    end else begin
      res = v[CoordBits-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/cgpw_axis.sv =====
// One coordinate axis: moves a point toward an anchor by a fraction, rounded and saturated.
module cgpw_axis #(
  parameter int unsigned COORD_WIDTH = cgpw_pkg::CoordWidthDefault
) (
  input  cgpw_pkg::coord_t p_i,
  input  cgpw_pkg::coord_t a_i,
  input  logic [15:0]      df_i,
  output cgpw_pkg::coord_t p_o
);

  localparam int unsigned SatWidth = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam cgpw_pkg::coord_t CoordMax = 16'((1 << (SatWidth - 1)) - 1);
  localparam cgpw_pkg::coord_t CoordMin = 16'(-(1 << (SatWidth - 1)));

  logic signed [16:0] diff;
  logic signed [33:0] diff_ext;
  logic signed [33:0] df_ext;
  logic signed [33:0] prod;
  logic signed [33:0] rnd;
  logic signed [17:0] quot;
  cgpw_pkg::wide_coord_t sum;

  assign diff     = 17'({a_i[15], a_i}) - 17'({p_i[15], p_i});
  assign diff_ext = {{17{diff[16]}}, diff};
  assign df_ext   = {18'b0, df_i};
  assign prod     = diff_ext * df_ext;
  assign rnd      = prod + 34'sd32768;
  assign quot     = rnd[33:16];
  assign sum      = cgpw_pkg::wide_coord_t'(p_i) + cgpw_pkg::wide_coord_t'(quot);
  assign p_o      = cgpw_pkg::sat_coord(sum, CoordMin, CoordMax);

endmodule

// ===== hw/rtl/chaos_game_point_walker_unit.sv =====
// Top level of the chaos-game point walker: registers, item handshakes and bounds tracking.
//
// Usage: anchors, the distance fraction and the start point are written through the
// configuration channel (cfg_valid_i/cfg_ready_o, index and 32-bit data) while the
// block is idle; cfg_ready_o is always high. Index 0 to ANCHOR_COUNT-1 selects an
// anchor, 4 the Q0.16 fraction and 5 the start point; other indices are ignored.
// Each item on the slave stream carries the mode in tuser (restart or step) and the
// target anchor in tdata. It is held in an input register and processed by one
// subtract, multiply, round and saturate per axis plus the bound compares (a restart
// instead loads the start point into point and bounds), and the result lands in the
// output register; one item per cycle is sustained while the master side takes results.
// A stalled master side holds the result register; the input register still takes
// one further item, after which s_axis_tready drops until the result is taken.
// Reset clears the point and bounds to zero, the anchors and start point to zero and
// the fraction to one half, and empties both registers.
module chaos_game_point_walker_unit #(
  parameter int unsigned ANCHOR_COUNT = cgpw_pkg::NumAnchorsDefault,
  parameter int unsigned COORD_WIDTH = cgpw_pkg::CoordWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cgpw_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [cgpw_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // target_index[1:0], zero pad
  input  logic [0:0]                          s_axis_tuser,  // mode[0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // point_x, point_y, min_x, max_x, min_y, max_y, 16 bits each from bit 0 up
  output logic [95:0]                         m_axis_tdata
);

  localparam int unsigned AncBits = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;
  localparam int unsigned SatWidth = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam cgpw_pkg::coord_t CoordMax = 16'((1 << (SatWidth - 1)) - 1);
  localparam cgpw_pkg::coord_t CoordMin = 16'(-(1 << (SatWidth - 1)));

  cgpw_pkg::coord_t anchor_x_q [ANCHOR_COUNT];
  cgpw_pkg::coord_t anchor_y_q [ANCHOR_COUNT];
  logic [15:0]      dist_q;
  cgpw_pkg::coord_t start_x_q, start_y_q;

  cgpw_pkg::coord_t cur_x_q, cur_y_q, low_x_q, high_x_q, low_y_q, high_y_q;
  cgpw_pkg::coord_t cur_x_d, cur_y_d, low_x_d, high_x_d, low_y_d, high_y_d;

  logic             in_valid_q;
  logic             mode_q;
  logic [1:0]       tgt_q;
  logic             out_valid_q;
  cgpw_pkg::result_t out_q;
  cgpw_pkg::result_t out_d;
  logic             fire;

  cgpw_pkg::coord_t cfg_lo_x, cfg_hi_y;
  cgpw_pkg::coord_t sel_ax, sel_ay, step_x, step_y;
  logic             tgt_ok;

  assign cfg_ready_o = 1'b1;
  assign cfg_lo_x = cgpw_pkg::sat_coord(cgpw_pkg::wide_coord_t'($signed(cfg_data_i[15:0])),
                                        CoordMin, CoordMax);
  assign cfg_hi_y = cgpw_pkg::sat_coord(cgpw_pkg::wide_coord_t'($signed(cfg_data_i[31:16])),
                                        CoordMin, CoordMax);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ANCHOR_COUNT; i++) begin
        anchor_x_q[i] <= '0;
        anchor_y_q[i] <= '0;
      end
      dist_q    <= cgpw_pkg::DistFactorReset;
      start_x_q <= '0;
      start_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (32'(cfg_index_i) < ANCHOR_COUNT) begin
        anchor_x_q[cfg_index_i[AncBits-1:0]] <= cfg_lo_x;
        anchor_y_q[cfg_index_i[AncBits-1:0]] <= cfg_hi_y;
      end else if (cfg_index_i == cgpw_pkg::CfgDistFactor) begin
        dist_q <= cfg_data_i[15:0];
      end else if (cfg_index_i == cgpw_pkg::CfgStartPoint) begin
        start_x_q <= cfg_lo_x;
        start_y_q <= cfg_hi_y;
      end
    end
  end

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q <= s_axis_tuser[0];
      tgt_q  <= s_axis_tdata[1:0];
    end
  end

  assign tgt_ok = (32'(tgt_q) < ANCHOR_COUNT);
  assign sel_ax = anchor_x_q[tgt_q[AncBits-1:0]];
  assign sel_ay = anchor_y_q[tgt_q[AncBits-1:0]];

  cgpw_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_x (
    .p_i (cur_x_q),
    .a_i (sel_ax),
    .df_i(dist_q),
    .p_o (step_x)
  );

  cgpw_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis_y (
    .p_i (cur_y_q),
    .a_i (sel_ay),
    .df_i(dist_q),
    .p_o (step_y)
  );

  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    low_x_d  = low_x_q;
    high_x_d = high_x_q;
    low_y_d  = low_y_q;
    high_y_d = high_y_q;
    if (mode_q) begin
      cur_x_d  = start_x_q;
      cur_y_d  = start_y_q;
      low_x_d  = start_x_q;
      high_x_d = start_x_q;
      low_y_d  = start_y_q;
      high_y_d = start_y_q;
    end else if (tgt_ok) begin
      cur_x_d = step_x;
      cur_y_d = step_y;
      if (step_x < low_x_q) begin
        low_x_d = step_x;
      end
      if (step_x > high_x_q) begin
        high_x_d = step_x;
      end
      if (step_y < low_y_q) begin
        low_y_d = step_y;
      end
      if (step_y > high_y_q) begin
        high_y_d = step_y;
      end
    end
    out_d.point_x = cur_x_d;
    out_d.point_y = cur_y_d;
    out_d.min_x   = low_x_d;
    out_d.max_x   = high_x_d;
    out_d.min_y   = low_y_d;
    out_d.max_y   = high_y_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      low_x_q  <= '0;
      high_x_q <= '0;
      low_y_q  <= '0;
      high_y_q <= '0;
    end else if (fire) begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      low_x_q  <= low_x_d;
      high_x_q <= high_x_d;
      low_y_q  <= low_y_d;
      high_y_q <= high_y_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== test/chaos_game_point_walker_checker.sv =====
// Item modes shared by the stimulus, and the checker that predicts and compares walker results.
`timescale 1ns / 1ps

package cgpw_tb_pkg;

  typedef enum logic {
    ModeStep    = 1'b0,
    ModeRestart = 1'b1
  } walk_mode_e;

  localparam int unsigned AnchorRegs = 4;

endpackage

module chaos_game_point_walker_checker #(
  parameter int unsigned ANCHOR_COUNT = 4,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_o,
  input  logic [cgpw_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [cgpw_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // target_index[1:0], zero pad
  input  logic [0:0]                          s_axis_tuser,  // mode[0]
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // point_x, point_y, min_x, max_x, min_y, max_y, 16 bits each from bit 0 up
  input  logic [95:0]                         m_axis_tdata,
  output int                                  failures_o,
  output int                                  pending_o
);

  import cgpw_pkg::coord_t;
  import cgpw_pkg::result_t;
  import cgpw_tb_pkg::*;

  localparam int unsigned SatWidth = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
  localparam longint CoordMax = (longint'(1) <<< (SatWidth - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;

  logic [31:0] anchor_q [AnchorRegs];
  logic [15:0] fraction_q;
  logic [31:0] start_q;
  coord_t pos_x, pos_y, lo_x, hi_x, lo_y, hi_y;
  result_t predicted_points [$];
  int mismatches = 0;

  assign failures_o = mismatches;
  assign pending_o  = predicted_points.size();

  function automatic coord_t clamp_to_range(longint v);
    if (v > CoordMax) return coord_t'(CoordMax);
    if (v < CoordMin) return coord_t'(CoordMin);
    return coord_t'(v);
  endfunction

  function automatic coord_t half_coord(logic [15:0] bits);
    return clamp_to_range(longint'($signed(bits)));
  endfunction

  // Rounds to nearest with halves upward: add one half, then floor by an arithmetic shift.
  function automatic coord_t step_axis(coord_t p, coord_t a);
    longint prod;
    prod = (longint'(a) - longint'(p)) * longint'(fraction_q);
    return clamp_to_range(longint'(p) + ((prod + 32768) >>> 16));
  endfunction

  function automatic result_t advance_walker(walk_mode_e mode, logic [1:0] tgt);
    result_t res;
    if (mode == ModeRestart) begin
      pos_x = half_coord(start_q[15:0]);
      pos_y = half_coord(start_q[31:16]);
      lo_x  = pos_x;
      hi_x  = pos_x;
      lo_y  = pos_y;
      hi_y  = pos_y;
    end else if (tgt < ANCHOR_COUNT) begin
      pos_x = step_axis(pos_x, half_coord(anchor_q[tgt][15:0]));
      pos_y = step_axis(pos_y, half_coord(anchor_q[tgt][31:16]));
      if (pos_x < lo_x) lo_x = pos_x;
      if (pos_x > hi_x) hi_x = pos_x;
      if (pos_y < lo_y) lo_y = pos_y;
      if (pos_y > hi_y) hi_y = pos_y;
    end
    res.point_x = pos_x;
    res.point_y = pos_y;
    res.min_x   = lo_x;
    res.max_x   = hi_x;
    res.min_y   = lo_y;
    res.max_y   = hi_y;
    return res;
  endfunction

  task automatic check_field(string name, coord_t want, coord_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      foreach (anchor_q[i]) anchor_q[i] = '0;
      fraction_q = cgpw_pkg::DistFactorReset;
      start_q    = '0;
      pos_x = '0;
      pos_y = '0;
      lo_x  = '0;
      hi_x  = '0;
      lo_y  = '0;
      hi_y  = '0;
      predicted_points.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == cgpw_pkg::CfgDistFactor) begin
          fraction_q = cfg_data_i[15:0];
        end else if (cfg_index_i == cgpw_pkg::CfgStartPoint) begin
          start_q = cfg_data_i;
        end else if (cfg_index_i < AnchorRegs) begin
          anchor_q[cfg_index_i] = cfg_data_i;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_points.push_back(
          advance_walker(walk_mode_e'(s_axis_tuser[0]), s_axis_tdata[1:0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        if (predicted_points.size() == 0) begin
          $error("Result item arrived with no expectation waiting: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = predicted_points.pop_front();
          check_field("point_x", want.point_x, got.point_x);
          check_field("point_y", want.point_y, got.point_y);
          check_field("min_x", want.min_x, got.min_x);
          check_field("max_x", want.max_x, got.max_x);
          check_field("min_y", want.min_y, got.min_y);
          check_field("max_y", want.max_y, got.max_y);
        end
      end
    end
  end

endmodule

// ===== test/chaos_game_point_walker_unit_tb.sv =====
// Testbench top for the chaos-game point walker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module chaos_game_point_walker_unit_tb;

  import cgpw_tb_pkg::*;

  localparam int unsigned NumAnchors = 4;
  localparam int unsigned CoordWidth = 16;
  localparam int unsigned RegSlots = 1 << cgpw_pkg::CfgIdxBits;
  localparam int CycleLimit = 300000;
  localparam int SegmentItems = 60;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [cgpw_pkg::CfgIdxBits-1:0] cfg_index_i = '0;
  logic [cgpw_pkg::CfgDataBits-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  int failures;
  int pending;
  int cycle_count = 0;
  int send_idle_pct = 14;
  int recv_idle_pct = 73;
  logic [31:0] reg_image [RegSlots];

  chaos_game_point_walker_unit #(
    .ANCHOR_COUNT(NumAnchors),
    .COORD_WIDTH(CoordWidth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  chaos_game_point_walker_checker #(
    .ANCHOR_COUNT(NumAnchors),
    .COORD_WIDTH(CoordWidth)
  ) walk_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .failures_o   (failures),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The valid line is left high after an item is taken; an idle in the next call or drain_walker lowers it.
  task automatic send_item(walk_mode_e mode, logic [1:0] tgt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {6'b0, tgt};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_walker();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes every index, the unused ones included, from the register image.
  task automatic load_registers();
    for (int i = 0; i < RegSlots; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[cgpw_pkg::CfgIdxBits-1:0];
      cfg_data_i  <= reg_image[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [15:0] pick_fraction();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h0001;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic randomise_registers();
    foreach (reg_image[i]) reg_image[i] = {pick_coord(), pick_coord()};
    reg_image[cgpw_pkg::CfgDistFactor] = {16'($urandom_range(16'hFFFF)), pick_fraction()};
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Steps straight out of reset work from a zero point with the default fraction.
    send_item(ModeStep, 2'd0);
    send_item(ModeStep, 2'd3);
    send_item(ModeRestart, 2'd1);
    drain_walker();

    // Corner anchors, the largest fraction with junk above it, and an extreme start.
    reg_image[0] = {16'h7FFF, 16'h7FFF};
    reg_image[1] = {16'h8000, 16'h8000};
    reg_image[2] = {16'h8000, 16'h7FFF};
    reg_image[3] = {16'hFFFF, 16'h0001};
    reg_image[cgpw_pkg::CfgDistFactor] = 32'hFFFF_FFFF;
    reg_image[cgpw_pkg::CfgStartPoint] = {16'h7FFF, 16'h8000};
    for (int i = cgpw_pkg::CfgStartPoint + 1; i < RegSlots; i++) reg_image[i] = $urandom;
    load_registers();
    send_item(ModeStep, 2'd0);
    send_item(ModeRestart, 2'd2);
    send_item(ModeStep, 2'd0);
    send_item(ModeStep, 2'd1);
    send_item(ModeStep, 2'd2);
    send_item(ModeStep, 2'd3);
    send_item(ModeStep, 2'd1);
    drain_walker();

    // One half with odd distances, so that exact halves round upward in both directions.
    reg_image[0] = {16'h0000, 16'h0001};
    reg_image[1] = {16'hFFFF, 16'h0000};
    reg_image[2] = {16'h0003, 16'hFFFD};
    reg_image[3] = 32'h0;
    reg_image[cgpw_pkg::CfgDistFactor] = {16'h0, cgpw_pkg::DistFactorReset};
    reg_image[cgpw_pkg::CfgStartPoint] = 32'h0;
    load_registers();
    send_item(ModeRestart, 2'd0);
    send_item(ModeStep, 2'd0);
    send_item(ModeStep, 2'd1);
    send_item(ModeStep, 2'd2);
    send_item(ModeStep, 2'd3);
    send_item(ModeStep, 2'd2);
    drain_walker();

    // A zero fraction keeps the point where it is.
    randomise_registers();
    reg_image[cgpw_pkg::CfgDistFactor] = 32'h0;
    reg_image[cgpw_pkg::CfgStartPoint] = {16'h1234, 16'hEDCB};
    load_registers();
    send_item(ModeRestart, 2'd3);
    send_item(ModeStep, 2'd0);
    send_item(ModeStep, 2'd3);
    drain_walker();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 73;
        end
        1: begin
          send_idle_pct = 73;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        randomise_registers();
        load_registers();
        send_item(ModeRestart, 2'($urandom_range(3)));
        for (int n = 1; n < SegmentItems; n++) begin
          send_item(($urandom_range(9) == 0) ? ModeRestart : ModeStep,
                    2'($urandom_range(3)));
        end
        drain_walker();
      end
    end

    repeat (8) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cgpw_pkg.sv
hw/rtl/cgpw_axis.sv
hw/rtl/chaos_game_point_walker_unit.sv
test/chaos_game_point_walker_checker.sv
test/chaos_game_point_walker_unit_tb.sv
